@@ hdl/imucf_pkg.sv @@
package imucf_pkg;

    // iteration counts
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 32;

    // datapath widths
    localparam int IN_W    = 16;
    localparam int EST_W   = 32;
    localparam int GAIN_W  = 32;
    localparam int MA_W    = 35;
    localparam int MB_W    = 17;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int INC_W   = 33;
    localparam int XY_W    = 36;
    localparam int Z_W     = 26;
    localparam int CNT_W   = 5;
    localparam int OP_W    = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_GAIN = 2'd1;

    localparam logic [15:0]       BLEND_WEIGHT_RST = 16'd32113;
    localparam logic [GAIN_W-1:0] GYRO_GAIN_RST    = 32'd327860;
    localparam logic [15:0]       ONE_Q15          = 16'd32768;

    // plus and minus ninety degrees in Q10.16
    localparam logic signed [Z_W-1:0] DEG90     = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] DEG90_NEG = -Z_W'(90 * 65536);

    // rounded atan(2^-i) in degrees, Q10.16
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [CNT_W-1:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                5'd0:    v = Z_W'(2949120);
                5'd1:    v = Z_W'(1740967);
                5'd2:    v = Z_W'(919879);
                5'd3:    v = Z_W'(466945);
                5'd4:    v = Z_W'(234379);
                5'd5:    v = Z_W'(117304);
                5'd6:    v = Z_W'(58666);
                5'd7:    v = Z_W'(29335);
                5'd8:    v = Z_W'(14668);
                5'd9:    v = Z_W'(7334);
                5'd10:   v = Z_W'(3667);
                5'd11:   v = Z_W'(1833);
                5'd12:   v = Z_W'(917);
                5'd13:   v = Z_W'(458);
                5'd14:   v = Z_W'(229);
                5'd15:   v = Z_W'(115);
                5'd16:   v = Z_W'(57);
                5'd17:   v = Z_W'(29);
                5'd18:   v = Z_W'(14);
                5'd19:   v = Z_W'(7);
                5'd20:   v = Z_W'(4);
                5'd21:   v = Z_W'(2);
                5'd22:   v = Z_W'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [EST_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        begin
            hi = PROD_W'(32'sh7fffffff);
            lo = -PROD_W'(33'sh080000000);
            if (v > hi) begin
                return 32'sh7fffffff;
            end else if (v < lo) begin
                return 32'sh80000000;
            end
            return v[EST_W-1:0];
        end
    endfunction

endpackage

@@ hdl/imu_complementary_attitude_filter.sv @@
// Complementary attitude filter for a six-axis IMU.
// Input channel (s_valid/s_ready) takes one sample word: three raw accelerometer
// axes and three raw gyro rates, 16-bit two's complement each.
// Result channel (m_valid/m_ready) gives roll, pitch and yaw in signed Q16.16
// degrees, one word per sample, after the state has been updated.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// blend_weight (index 0, Q1.15) and gyro_step_gain (index 1, Q0.32); it is
// always ready and should only be used while no sample is in work.
// A new sample is taken only after the previous result has been loaded into the
// output register. The work runs through one shared 35x17 multiplier (nine
// products), the 32-step bit-pair square root, and two 16-step CORDIC passes
// through one shift/add unit.
// Reset clears the three estimates to zero, loads the register defaults and
// leaves the output empty. A stalled receiver holds the finished word in the
// output register; the next sample may be accepted meanwhile, but its result
// waits until the previous word has been taken.
module imu_complementary_attitude_filter (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [imucf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [31:0]                              cfg_data,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [imucf_pkg::IN_W-1:0]        s_accel_x,
    input  logic signed [imucf_pkg::IN_W-1:0]        s_accel_y,
    input  logic signed [imucf_pkg::IN_W-1:0]        s_accel_z,
    input  logic signed [imucf_pkg::IN_W-1:0]        s_gyro_x,
    input  logic signed [imucf_pkg::IN_W-1:0]        s_gyro_y,
    input  logic signed [imucf_pkg::IN_W-1:0]        s_gyro_z,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [imucf_pkg::EST_W-1:0]       m_roll_deg,
    output logic signed [imucf_pkg::EST_W-1:0]       m_pitch_deg,
    output logic signed [imucf_pkg::EST_W-1:0]       m_yaw_deg
);
    import imucf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQRT, S_CSETUP, S_CITER, S_BLEND, S_OUT
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [OP_W-1:0]          op_reg;
    logic                     pass_reg;

    logic [15:0]              blend_weight_reg;
    logic [GAIN_W-1:0]        gain_reg;

    logic signed [IN_W-1:0]   ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;

    logic signed [EST_W-1:0]  roll_reg, pitch_reg, yaw_reg;
    logic signed [INC_W-1:0]  inc_r_reg, inc_p_reg, inc_y_reg;
    logic [31:0]              mag_reg;

    logic [63:0]              rad_reg;
    logic [34:0]              rem_reg;
    logic [31:0]              root_reg;

    logic signed [XY_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic                     zero_reg;
    logic signed [Z_W-1:0]    roll_ang_reg, pitch_ang_reg;

    logic signed [PROD_W-1:0] prod_reg, acc_reg;

    logic                     m_valid_reg;
    logic signed [EST_W-1:0]  m_roll_reg, m_pitch_reg, m_yaw_reg;

    // shared multiplier operands
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [15:0]              alpha;
    logic [15:0]              beta;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [INC_W-1:0]  inc_val;
    logic signed [PROD_W-1:0] blend_sum;
    logic signed [PROD_W-1:0] blend_shr;
    logic signed [EST_W-1:0]  blend_sat;

    // square-root step
    logic [34:0]              rem_sh;
    logic [34:0]              trial;
    logic                     take;

    // cordic
    logic signed [XY_W-1:0]   cx, cy, xs, ys;
    logic signed [XY_W-1:0]   sx, sy;
    logic signed [Z_W-1:0]    sz;
    logic signed [Z_W-1:0]    ang_step;

    assign alpha = (blend_weight_reg > ONE_Q15) ? ONE_Q15 : blend_weight_reg;
    assign beta  = ONE_Q15 - alpha;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL) begin
            case (op_reg)
                3'd0: begin
                    mul_a = $signed({3'b000, gain_reg});
                    mul_b = MB_W'(gx_reg);
                end
                3'd1: begin
                    mul_a = $signed({3'b000, gain_reg});
                    mul_b = MB_W'(gy_reg);
                end
                3'd2: begin
                    mul_a = $signed({3'b000, gain_reg});
                    mul_b = MB_W'(gz_reg);
                end
                3'd3: begin
                    mul_a = MA_W'(ay_reg);
                    mul_b = MB_W'(ay_reg);
                end
                3'd4: begin
                    mul_a = MA_W'(az_reg);
                    mul_b = MB_W'(az_reg);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (state_reg == S_BLEND) begin
            case (op_reg)
                3'd0: begin
                    mul_a = MA_W'(roll_reg) + MA_W'(inc_r_reg);
                    mul_b = $signed({1'b0, alpha});
                end
                3'd1: begin
                    mul_a = MA_W'(roll_ang_reg);
                    mul_b = $signed({1'b0, beta});
                end
                3'd2: begin
                    mul_a = MA_W'(pitch_reg) + MA_W'(inc_p_reg);
                    mul_b = $signed({1'b0, alpha});
                end
                3'd3: begin
                    mul_a = MA_W'(pitch_ang_reg);
                    mul_b = $signed({1'b0, beta});
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // rounding of the registered product
    always_comb begin
        prod_rnd  = prod_reg + PROD_W'(32768);
        inc_val   = prod_rnd[16 +: INC_W];
        blend_sum = acc_reg + prod_reg + PROD_W'(16384);
        blend_shr = blend_sum >>> 15;
        blend_sat = sat32(blend_shr);
    end

    // one bit pair of the square root
    always_comb begin
        rem_sh = {rem_reg[32:0], rad_reg[63:62]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    // cordic setup with quadrant fold, and one vectoring step
    always_comb begin
        if (!pass_reg) begin
            cy = {{(XY_W-32){ay_reg[IN_W-1]}}, ay_reg, 16'b0};
            cx = {{(XY_W-32){az_reg[IN_W-1]}}, az_reg, 16'b0};
        end else begin
            cy = -{{(XY_W-32){ax_reg[IN_W-1]}}, ax_reg, 16'b0};
            cx = {{(XY_W-32){1'b0}}, root_reg};
        end
        if (cx[XY_W-1]) begin
            if (!cy[XY_W-1]) begin
                sx = cy;
                sy = -cx;
                sz = DEG90;
            end else begin
                sx = -cy;
                sy = cx;
                sz = DEG90_NEG;
            end
        end else begin
            sx = cx;
            sy = cy;
            sz = '0;
        end
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        ang_step = atan_q16(cnt_reg);
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_roll_deg  = m_roll_reg;
    assign m_pitch_deg = m_pitch_reg;
    assign m_yaw_deg   = m_yaw_reg;

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            op_reg           <= '0;
            pass_reg         <= 1'b0;
            blend_weight_reg <= BLEND_WEIGHT_RST;
            gain_reg         <= GYRO_GAIN_RST;
            roll_reg         <= '0;
            pitch_reg        <= '0;
            yaw_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                if (cfg_index == REG_BLEND_WEIGHT) begin
                    blend_weight_reg <= cfg_data[15:0];
                end else if (cfg_index == REG_GYRO_STEP_GAIN) begin
                    gain_reg <= cfg_data;
                end
            end

            // output word taken, unless a new one is loaded in the same cycle
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ax_reg    <= s_accel_x;
                        ay_reg    <= s_accel_y;
                        az_reg    <= s_accel_z;
                        gx_reg    <= s_gyro_x;
                        gy_reg    <= s_gyro_y;
                        gz_reg    <= s_gyro_z;
                        op_reg    <= '0;
                        state_reg <= S_MUL;
                    end
                end
                // gyro increments and squared magnitude
                S_MUL: begin
                    op_reg <= op_reg + 3'd1;
                    case (op_reg)
                        3'd1: inc_r_reg <= inc_val;
                        3'd2: inc_p_reg <= inc_val;
                        3'd3: inc_y_reg <= inc_val;
                        3'd4: mag_reg   <= prod_reg[31:0];
                        3'd5: begin
                            rad_reg   <= {mag_reg + prod_reg[31:0], 32'b0};
                            rem_reg   <= '0;
                            root_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_SQRT;
                        end
                        default: ;
                    endcase
                end
                // horizontal magnitude, two radicand bits a cycle
                S_SQRT: begin
                    rad_reg <= {rad_reg[61:0], 2'b00};
                    if (take) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                        pass_reg  <= 1'b0;
                        state_reg <= S_CSETUP;
                    end
                end
                S_CSETUP: begin
                    x_reg     <= sx;
                    y_reg     <= sy;
                    z_reg     <= sz;
                    zero_reg  <= (cx == '0) && (cy == '0);
                    cnt_reg   <= '0;
                    state_reg <= S_CITER;
                end
                S_CITER: begin
                    if (!y_reg[XY_W-1]) begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + ang_step;
                    end else begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - ang_step;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                        if (!pass_reg) begin
                            roll_ang_reg <= zero_reg ? '0 :
                                ((!y_reg[XY_W-1]) ? z_reg + ang_step : z_reg - ang_step);
                            pass_reg     <= 1'b1;
                            state_reg    <= S_CSETUP;
                        end else begin
                            pitch_ang_reg <= zero_reg ? '0 :
                                ((!y_reg[XY_W-1]) ? z_reg + ang_step : z_reg - ang_step);
                            op_reg        <= '0;
                            state_reg     <= S_BLEND;
                        end
                    end
                end
                // weighted blend of gyro path and accel angle; yaw is gyro only
                S_BLEND: begin
                    op_reg <= op_reg + 3'd1;
                    case (op_reg)
                        3'd1: acc_reg <= prod_reg;
                        3'd2: roll_reg <= blend_sat;
                        3'd3: acc_reg <= prod_reg;
                        3'd4: begin
                            pitch_reg <= blend_sat;
                            yaw_reg   <= sat32(PROD_W'(yaw_reg) + PROD_W'(inc_y_reg));
                            state_reg <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_roll_reg  <= roll_reg;
                        m_pitch_reg <= pitch_reg;
                        m_yaw_reg   <= yaw_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
